// ----- src/clist_pkg.sv -----
`default_nettype none
package clist_pkg;

  localparam int unsigned ClistCapacity = 256;

  localparam logic [3:0] OP_CLEAR      = 4'd0;
  localparam logic [3:0] OP_PREPEND    = 4'd1;
  localparam logic [3:0] OP_APPEND     = 4'd2;
  localparam logic [3:0] OP_INS_BEFORE = 4'd3;
  localparam logic [3:0] OP_INS_AFTER  = 4'd4;
  localparam logic [3:0] OP_DEL_FRONT  = 4'd5;
  localparam logic [3:0] OP_DEL_BACK   = 4'd6;
  localparam logic [3:0] OP_DEL_CURSOR = 4'd7;
  localparam logic [3:0] OP_FRONT      = 4'd8;
  localparam logic [3:0] OP_BACK       = 4'd9;
  localparam logic [3:0] OP_PREV       = 4'd10;
  localparam logic [3:0] OP_NEXT       = 4'd11;
  localparam logic [3:0] OP_GET        = 4'd12;
  localparam logic [3:0] OP_SET        = 4'd13;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOCUR = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

endpackage
`default_nettype wire

// ----- src/clist_ram.sv -----
`default_nettype none
module clist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- src/cursor_list_engine.sv -----
// steps: a command is accepted only in idle and passes through the link, update
// and output steps before its result word is registered; the link read, the value
// read of the neighbor node and the link writeback form one read-modify-write
// sequence, and a stalled result word holds the engine in its output step
// reset: rst_ni clears list pointers, counters and handshake state at once;
// node memories are not cleared; no entry's data is used before it is written
`default_nettype none
module cursor_list_engine
  import clist_pkg::*;
#(
  parameter int unsigned Capacity = ClistCapacity,
  localparam int unsigned Aw = $clog2(Capacity),
  localparam int unsigned Lw = $clog2(Capacity + 1),
  localparam int unsigned Pw = Aw + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [3:0]         op_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [31:0]      cursor_value_o,
  output logic signed [31:0]      front_value_o,
  output logic signed [31:0]      back_value_o,
  output logic [Lw-1:0]           count_o,
  output logic signed [Pw-1:0]    cursor_index_o
);

  localparam logic [Lw-1:0] Nil = Lw'(Capacity);
  localparam logic [Lw-1:0] CapL = Lw'(Capacity);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LINK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [3:0] op_q;
  logic [31:0] v_q;
  logic [1:0] st_q;
  logic act_q;
  logic [Lw-1:0] p_q, q_q, n_q;

  logic [Lw-1:0] first_q, last_q, cur_q, cnt_q, freed_q, nu_q;
  logic signed [Pw-1:0] pos_q;
  logic [31:0] front_val_q, back_val_q, cur_val_q;

  // memory ports
  logic          fwd_we, bwd_we, val_we, stk_we;
  logic [Aw-1:0] fwd_wa, bwd_wa, val_wa, stk_wa;
  logic [Lw-1:0] fwd_wd, bwd_wd;
  logic [31:0]   val_wd;
  logic [Aw-1:0] stk_wd;
  logic [Aw-1:0] link_ra, val_ra, stk_ra;
  logic [Lw-1:0] fwd_rd, bwd_rd;
  logic [31:0]   val_rd;
  logic [Aw-1:0] stk_rd;

  clist_ram #(.Width(Lw), .Depth(Capacity)) u_fwd (
    .clk_i, .we_i(fwd_we), .waddr_i(fwd_wa), .wdata_i(fwd_wd),
    .raddr_i(link_ra), .rdata_o(fwd_rd)
  );
  clist_ram #(.Width(Lw), .Depth(Capacity)) u_bwd (
    .clk_i, .we_i(bwd_we), .waddr_i(bwd_wa), .wdata_i(bwd_wd),
    .raddr_i(link_ra), .rdata_o(bwd_rd)
  );
  clist_ram #(.Width(32), .Depth(Capacity)) u_val (
    .clk_i, .we_i(val_we), .waddr_i(val_wa), .wdata_i(val_wd),
    .raddr_i(val_ra), .rdata_o(val_rd)
  );
  clist_ram #(.Width(Aw), .Depth(Capacity)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

  logic in_acc, empty, curdef, can_alloc;
  logic [1:0] st_new;
  logic act_new;
  logic [Lw-1:0] n_new, k_del;
  logic [Lw-1:0] pos_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign empty      = (cnt_q == '0);
  assign curdef     = (cur_q != Nil);
  assign can_alloc  = (freed_q != '0) || (nu_q < CapL);
  assign n_new      = (freed_q != '0) ? Lw'(stk_rd) : nu_q;
  assign pos_inc    = Lw'(pos_q[Aw-1:0]) + Lw'(1);

  always_comb begin
    case (op_q)
      OP_DEL_FRONT: k_del = first_q;
      OP_DEL_BACK:  k_del = last_q;
      default:      k_del = cur_q;
    endcase
  end

  // error checks on the incoming command
  always_comb begin
    st_new  = ST_OK;
    act_new = 1'b1;
    unique case (op_i) inside
      OP_CLEAR: ;
      OP_PREPEND, OP_APPEND: begin
        if (!can_alloc) st_new = ST_FULL;
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (empty) st_new = ST_EMPTY;
        else if (!curdef) st_new = ST_NOCUR;
        else if (!can_alloc) st_new = ST_FULL;
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_FRONT, OP_BACK: begin
        if (empty) st_new = ST_EMPTY;
      end
      OP_DEL_CURSOR, OP_GET, OP_SET: begin
        if (empty) st_new = ST_EMPTY;
        else if (!curdef) st_new = ST_NOCUR;
      end
      OP_PREV, OP_NEXT: begin
        if (!curdef) st_new = ST_NOCUR;
      end
      default: act_new = 1'b0;
    endcase
    if (st_new != ST_OK) act_new = 1'b0;
  end

  always_comb begin
    case (op_i)
      OP_DEL_FRONT: link_ra = first_q[Aw-1:0];
      OP_DEL_BACK:  link_ra = last_q[Aw-1:0];
      default:      link_ra = cur_q[Aw-1:0];
    endcase
    stk_ra = Aw'(freed_q - Lw'(1));
  end

  // memory writes: first half in S_LINK, second half in S_UPD
  always_comb begin
    fwd_we = 1'b0; fwd_wa = '0; fwd_wd = '0;
    bwd_we = 1'b0; bwd_wa = '0; bwd_wd = '0;
    val_we = 1'b0; val_wa = '0; val_wd = v_q;
    stk_we = 1'b0; stk_wa = freed_q[Aw-1:0]; stk_wd = k_del[Aw-1:0];
    val_ra = '0;
    if (state_q == S_LINK && act_q) begin
      case (op_q) inside
        OP_PREPEND: begin
          fwd_we = 1'b1; fwd_wa = n_new[Aw-1:0]; fwd_wd = first_q;
          bwd_we = 1'b1; bwd_wa = n_new[Aw-1:0]; bwd_wd = Nil;
        end
        OP_APPEND: begin
          fwd_we = 1'b1; fwd_wa = n_new[Aw-1:0]; fwd_wd = Nil;
          bwd_we = 1'b1; bwd_wa = n_new[Aw-1:0]; bwd_wd = last_q;
        end
        OP_INS_BEFORE: begin
          fwd_we = 1'b1; fwd_wa = n_new[Aw-1:0]; fwd_wd = cur_q;
          bwd_we = 1'b1; bwd_wa = n_new[Aw-1:0]; bwd_wd = bwd_rd;
        end
        OP_INS_AFTER: begin
          fwd_we = 1'b1; fwd_wa = n_new[Aw-1:0]; fwd_wd = fwd_rd;
          bwd_we = 1'b1; bwd_wa = n_new[Aw-1:0]; bwd_wd = cur_q;
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_CURSOR: begin
          fwd_we = (bwd_rd != Nil); fwd_wa = bwd_rd[Aw-1:0]; fwd_wd = fwd_rd;
          bwd_we = (fwd_rd != Nil); bwd_wa = fwd_rd[Aw-1:0]; bwd_wd = bwd_rd;
          stk_we = (freed_q < CapL);
        end
        default: ;
      endcase
      case (op_q) inside
        OP_PREPEND, OP_APPEND, OP_INS_BEFORE, OP_INS_AFTER: begin
          val_we = 1'b1; val_wa = n_new[Aw-1:0];
        end
        OP_SET: begin
          val_we = 1'b1; val_wa = cur_q[Aw-1:0];
        end
        default: ;
      endcase
      // neighbor whose value becomes front, back or cursor value
      case (op_q) inside
        OP_DEL_FRONT, OP_NEXT: val_ra = fwd_rd[Aw-1:0];
        OP_DEL_CURSOR: val_ra = (cur_q == first_q) ? fwd_rd[Aw-1:0] : bwd_rd[Aw-1:0];
        default: val_ra = bwd_rd[Aw-1:0];
      endcase
    end else if (state_q == S_UPD && act_q) begin
      case (op_q)
        OP_PREPEND: begin
          bwd_we = (first_q != Nil); bwd_wa = first_q[Aw-1:0]; bwd_wd = n_q;
        end
        OP_APPEND: begin
          fwd_we = (last_q != Nil); fwd_wa = last_q[Aw-1:0]; fwd_wd = n_q;
        end
        OP_INS_BEFORE: begin
          fwd_we = (p_q != Nil); fwd_wa = p_q[Aw-1:0]; fwd_wd = n_q;
          bwd_we = 1'b1; bwd_wa = cur_q[Aw-1:0]; bwd_wd = n_q;
        end
        OP_INS_AFTER: begin
          bwd_we = (q_q != Nil); bwd_wa = q_q[Aw-1:0]; bwd_wd = n_q;
          fwd_we = 1'b1; fwd_wa = cur_q[Aw-1:0]; fwd_wd = n_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_LINK;
      S_LINK: state_d = S_UPD;
      S_UPD:  state_d = S_OUT;
      S_OUT:  if (!out_valid_o || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= op_i;
      v_q   <= value_i;
      st_q  <= st_new;
    end
    if (state_q == S_LINK) begin
      p_q <= bwd_rd;
      q_q <= fwd_rd;
      n_q <= n_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= 1'b0;
      first_q     <= Nil;
      last_q      <= Nil;
      cur_q       <= Nil;
      pos_q       <= '1;
      cnt_q       <= '0;
      freed_q     <= '0;
      nu_q        <= '0;
      front_val_q <= '0;
      back_val_q  <= '0;
      cur_val_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) act_q <= act_new;
      if (state_q == S_UPD && act_q) begin
        case (op_q) inside
          OP_CLEAR: begin
            first_q <= Nil; last_q <= Nil; cur_q <= Nil; pos_q <= '1;
            cnt_q <= '0; freed_q <= '0; nu_q <= '0;
          end
          OP_PREPEND, OP_APPEND, OP_INS_BEFORE, OP_INS_AFTER: begin
            cnt_q <= cnt_q + Lw'(1);
            if (freed_q != '0) freed_q <= freed_q - Lw'(1);
            else nu_q <= nu_q + Lw'(1);
            case (op_q)
              OP_PREPEND: begin
                first_q <= n_q; front_val_q <= v_q;
                if (first_q == Nil) begin last_q <= n_q; back_val_q <= v_q; end
                if (curdef) pos_q <= pos_q + Pw'(1);
              end
              OP_APPEND: begin
                last_q <= n_q; back_val_q <= v_q;
                if (last_q == Nil) begin first_q <= n_q; front_val_q <= v_q; end
              end
              OP_INS_BEFORE: begin
                if (p_q == Nil) begin first_q <= n_q; front_val_q <= v_q; end
                pos_q <= pos_q + Pw'(1);
              end
              default: begin
                if (q_q == Nil) begin last_q <= n_q; back_val_q <= v_q; end
              end
            endcase
          end
          OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_CURSOR: begin
            cnt_q <= cnt_q - Lw'(1);
            if (freed_q < CapL) freed_q <= freed_q + Lw'(1);
            if (p_q == Nil) begin first_q <= q_q; front_val_q <= val_rd; end
            if (q_q == Nil) begin last_q <= p_q; back_val_q <= val_rd; end
            if (curdef) begin
              if (cur_q == k_del) begin
                cur_q <= Nil; pos_q <= '1;
              end else if (op_q == OP_DEL_FRONT) begin
                pos_q <= pos_q - Pw'(1);
              end
            end
          end
          OP_FRONT: begin
            cur_q <= first_q; pos_q <= '0; cur_val_q <= front_val_q;
          end
          OP_BACK: begin
            cur_q <= last_q; cur_val_q <= back_val_q;
            pos_q <= {1'b0, Aw'(cnt_q - Lw'(1))};
          end
          OP_PREV: begin
            if (pos_q > 0) begin
              cur_q <= p_q; pos_q <= pos_q - Pw'(1); cur_val_q <= val_rd;
            end else begin
              cur_q <= Nil; pos_q <= '1;
            end
          end
          OP_NEXT: begin
            if (pos_inc < cnt_q) begin
              cur_q <= q_q; pos_q <= pos_q + Pw'(1); cur_val_q <= val_rd;
            end else begin
              cur_q <= Nil; pos_q <= '1;
            end
          end
          OP_SET: begin
            cur_val_q <= v_q;
            if (cur_q == first_q) front_val_q <= v_q;
            if (cur_q == last_q) back_val_q <= v_q;
          end
          default: ;
        endcase
      end
      if (state_q == S_OUT && (!out_valid_o || !out_stall_i)) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // result word, loaded when the output side is free
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_o || !out_stall_i)) begin
      status_o       <= st_q;
      cursor_value_o <= curdef ? cur_val_q : '0;
      front_value_o  <= empty ? '0 : front_val_q;
      back_value_o   <= empty ? '0 : back_val_q;
      count_o        <= cnt_q;
      cursor_index_o <= curdef ? pos_q : '1;
    end
  end

  a_first_nil_iff_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_q == Nil) == (cnt_q == '0))
    else $error("front pointer and element count disagree");

  a_cursor_nil_iff_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q == Nil) == (pos_q == '1))
    else $error("cursor node and cursor index disagree");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CapL) && (freed_q <= CapL) && (nu_q <= CapL))
    else $error("counter beyond pool size");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("result word raised outside output step");

endmodule
`default_nettype wire
